@@ design/ist_pkg.sv @@
// shared types and constants for the integer set table
// no dependencies; imported by the interfaces, datapath, controller and top level
package ist_pkg;

   localparam int ValueWidth = 32;
   localparam int CountOutWidth = 5;

   typedef logic [1:0] op_type;

   localparam op_type OP_ADD      = 2'd0;
   localparam op_type OP_REMOVE   = 2'd1;
   localparam op_type OP_CONTAINS = 2'd2;
   localparam op_type OP_DUMP     = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic accept;    // latch request, start first scan
      logic scan;      // run one scan step
      logic rescan;    // start next dump pass
      logic last_rd;   // read the last occupied entry
      logic add_wr;    // append value
      logic rem_wr;    // move last entry into the found slot
      logic load_rsp;  // load the response register
   } ist_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic   scan_done;
      logic   found;
      logic   full;
      logic   dump_last;
      op_type op;
   } ist_sts_type;

endpackage

@@ design/ist_if.sv @@
// request and response channel interfaces of the integer set table
// depends on ist_pkg
interface ist_req_if;
   logic                                valid;
   logic                                ready;
   ist_pkg::op_type                     operation;
   logic signed [ist_pkg::ValueWidth-1:0] value;

   modport source (output valid, operation, value, input ready);
   modport sink (input valid, operation, value, output ready);
endinterface

interface ist_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     was_present;
   logic                                     rejected_full;
   logic [ist_pkg::CountOutWidth-1:0]        member_count;
   logic signed [ist_pkg::ValueWidth-1:0]    element;
   logic                                     element_valid;
   logic                                     last;

   modport source (output valid, was_present, rejected_full, member_count, element,
                   element_valid, last, input ready);
   modport sink (input valid, was_present, rejected_full, member_count, element,
                 element_valid, last, output ready);
endinterface

@@ design/ist_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module ist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/ist_datapath.sv @@
// datapath of the integer set table: member store, scan unit, count and response word
// depends on ist_pkg and ist_ram
module ist_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ist_pkg::ist_cmd_type                   cmd,
   output ist_pkg::ist_sts_type                   sts,
   input  ist_pkg::op_type                        req_operation,
   input  logic signed [ist_pkg::ValueWidth-1:0]  req_value,
   output logic                                   rsp_was_present,
   output logic                                   rsp_rejected_full,
   output logic [ist_pkg::CountOutWidth-1:0]      rsp_member_count,
   output logic signed [ist_pkg::ValueWidth-1:0]  rsp_element,
   output logic                                   rsp_element_valid,
   output logic                                   rsp_last
);
   import ist_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   op_type                 op_ff;
   logic signed [ValueWidth-1:0] value_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          scan_idx_ff, scan_idx_in;
   logic                   pend_ff, pend_in;
   logic [IW-1:0]          pend_idx_ff, pend_idx_in;
   logic                   found_ff, found_in;
   logic [IW-1:0]          slot_ff, slot_in;
   logic signed [ValueWidth-1:0] best_ff, best_in;
   logic                   best_valid_ff, best_valid_in;
   logic signed [ValueWidth-1:0] prev_ff, prev_in;
   logic                   prev_valid_ff, prev_valid_in;
   logic [CW-1:0]          emitted_ff, emitted_in;
   logic                   added_ff;

   logic                   was_present_ff, rejected_full_ff, element_valid_ff, last_ff;
   logic [CW-1:0]          member_count_ff;
   logic signed [ValueWidth-1:0] element_ff;

   logic                   wr_en;
   logic [IW-1:0]          wr_addr, rd_addr;
   logic [ValueWidth-1:0]  wr_data, rd_raw;
   logic signed [ValueWidth-1:0] rd_data;
   logic [CW-1:0]          count_m1, emitted_p1;
   logic [CW+CountOutWidth-1:0] count_ext;
   logic                   issue, is_dump, empty, full, dump_last;
   logic                   above_prev, below_best;

   assign count_m1   = count_ff - CW'(1);
   assign emitted_p1 = emitted_ff + CW'(1);
   assign issue      = cmd.scan && (scan_idx_ff < count_ff);
   assign is_dump    = (op_ff == OP_DUMP);
   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CW'(CAPACITY));
   assign dump_last  = empty || (emitted_p1 == count_ff);
   assign rd_data    = rd_raw;

   // signed ordering for the dump search
   assign above_prev = !prev_valid_ff || (rd_data > prev_ff);
   assign below_best = !best_valid_ff || (rd_data < best_ff);

   // member store
   assign rd_addr = cmd.last_rd ? count_m1[IW-1:0] : scan_idx_ff[IW-1:0];
   assign wr_en   = cmd.add_wr || cmd.rem_wr;
   assign wr_addr = cmd.add_wr ? count_ff[IW-1:0] : slot_ff;
   assign wr_data = cmd.add_wr ? value_ff : rd_raw;

   ist_ram #(
      .WIDTH (ValueWidth),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   always_comb begin
      scan_idx_in   = scan_idx_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      best_in       = best_ff;
      best_valid_in = best_valid_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      emitted_in    = emitted_ff;
      count_in      = count_ff;
      if (cmd.accept) begin
         scan_idx_in   = '0;
         pend_in       = 1'b0;
         found_in      = 1'b0;
         best_valid_in = 1'b0;
         prev_valid_in = 1'b0;
         emitted_in    = '0;
      end else if (cmd.rescan) begin
         scan_idx_in   = '0;
         pend_in       = 1'b0;
         best_valid_in = 1'b0;
         prev_in       = best_ff;
         prev_valid_in = 1'b1;
         emitted_in    = emitted_p1;
      end else begin
         // issue one read per cycle, compare the word that comes back next cycle
         pend_in = issue;
         if (issue) begin
            scan_idx_in = scan_idx_ff + CW'(1);
            pend_idx_in = scan_idx_ff[IW-1:0];
         end
         if (pend_ff) begin
            if (is_dump) begin
               if (above_prev && below_best) begin
                  best_in       = rd_data;
                  best_valid_in = 1'b1;
               end
            end else if (rd_data == value_ff) begin
               found_in = 1'b1;
               slot_in  = pend_idx_ff;
            end
         end
      end
      if (cmd.add_wr) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.rem_wr) begin
         count_in = count_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         scan_idx_ff   <= '0;
         found_ff      <= 1'b0;
         best_valid_ff <= 1'b0;
         prev_valid_ff <= 1'b0;
         emitted_ff    <= '0;
         added_ff      <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         scan_idx_ff   <= scan_idx_in;
         found_ff      <= found_in;
         best_valid_ff <= best_valid_in;
         prev_valid_ff <= prev_valid_in;
         emitted_ff    <= emitted_in;
         added_ff      <= cmd.add_wr;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      slot_ff     <= slot_in;
      best_ff     <= best_in;
      prev_ff     <= prev_in;
      if (cmd.accept) begin
         op_ff    <= req_operation;
         value_ff <= req_value;
      end
      if (cmd.load_rsp) begin
         was_present_ff   <= !is_dump && found_ff;
         // after an append the count already holds the new value
         rejected_full_ff <= (op_ff == OP_ADD) && !found_ff && full && !added_ff;
         member_count_ff  <= count_ff;
         element_ff       <= (is_dump && !empty) ? best_ff : '0;
         element_valid_ff <= is_dump && !empty;
         last_ff          <= !is_dump || dump_last;
      end
   end

   assign sts.scan_done = !pend_ff && !(scan_idx_ff < count_ff);
   assign sts.found     = found_ff;
   assign sts.full      = full;
   assign sts.dump_last = dump_last;
   assign sts.op        = op_ff;

   assign count_ext         = {{CountOutWidth{1'b0}}, member_count_ff};
   assign rsp_was_present   = was_present_ff;
   assign rsp_rejected_full = rejected_full_ff;
   assign rsp_member_count  = count_ext[CountOutWidth-1:0];
   assign rsp_element       = element_ff;
   assign rsp_element_valid = element_valid_ff;
   assign rsp_last          = last_ff;

endmodule

@@ design/ist_controller.sv @@
// controller of the integer set table: sequences scans, writes and response words
// depends on ist_pkg
module ist_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ist_pkg::ist_sts_type sts,
   output ist_pkg::ist_cmd_type cmd
);
   import ist_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_REM_WR = 3'd2;
   localparam logic [2:0] S_LOAD   = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               if (sts.op == OP_DUMP) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = S_RESP;
               end else if (sts.op == OP_ADD && !sts.found && !sts.full) begin
                  cmd.add_wr = 1'b1;
                  state_in   = S_LOAD;
               end else if (sts.op == OP_REMOVE && sts.found) begin
                  cmd.last_rd = 1'b1;
                  state_in    = S_REM_WR;
               end else begin
                  cmd.load_rsp = 1'b1;
                  state_in     = S_RESP;
               end
            end
         end
         S_REM_WR: begin
            cmd.rem_wr = 1'b1;
            state_in   = S_LOAD;
         end
         S_LOAD: begin
            cmd.load_rsp = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               if (sts.op == OP_DUMP && !sts.dump_last) begin
                  cmd.rescan = 1'b1;
                  state_in   = S_SCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/integer_set_table_core.sv @@
// integer set table: add, remove, contains and sorted dump over up to CAPACITY members
// add/remove/contains: one response word, after a scan of the stored entries and any write
// dump: one word per member in ascending signed order, each after a fresh scan once the last is taken
// a new request is accepted on the cycle after the last word of the previous one has gone
// the single ram read port scans one entry per cycle
// synchronous active-high reset empties the set; stored entries are not cleared
module integer_set_table_core #(
   parameter int CAPACITY = 16
) (
   input  logic          clock,
   input  logic          reset,
   ist_req_if.sink       req_ch,
   ist_rsp_if.source     rsp_ch
);
   import ist_pkg::*;

   // command and status between sequencer and datapath
   ist_cmd_type cmd;
   ist_sts_type sts;

   // sequencer: owns the handshakes, one request in flight at a time
   ist_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: member ram, scan/compare unit, member count and response register
   ist_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_ch.operation),
      .req_value         (req_ch.value),
      .rsp_was_present   (rsp_ch.was_present),
      .rsp_rejected_full (rsp_ch.rejected_full),
      .rsp_member_count  (rsp_ch.member_count),
      .rsp_element       (rsp_ch.element),
      .rsp_element_valid (rsp_ch.element_valid),
      .rsp_last          (rsp_ch.last)
   );

endmodule

@@ design/ist_checker.sv @@
// port-level checks for the integer set table, bound to the top level
// depends on integer_set_table_core and ist_pkg
module ist_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  rsp_was_present,
   input logic                                  rsp_rejected_full,
   input logic signed [ist_pkg::ValueWidth-1:0] rsp_element,
   input logic                                  rsp_element_valid,
   input logic                                  rsp_last
);

   // a response word waits until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped before taken");

   // one request at a time: never ready while a word waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");

   // the last word of a request returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid && req_ready)
      else $error("block not idle after last word");

   // a dump word carries no lookup flags
   a_dump_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_element_valid |-> !rsp_was_present && !rsp_rejected_full)
      else $error("dump word with lookup flags");

   // element is zero unless it carries a member
   a_elem_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_element_valid |-> rsp_element == '0)
      else $error("element not zero without a member");

endmodule

bind integer_set_table_core ist_checker u_ist_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_was_present   (rsp_ch.was_present),
   .rsp_rejected_full (rsp_ch.rejected_full),
   .rsp_element       (rsp_ch.element),
   .rsp_element_valid (rsp_ch.element_valid),
   .rsp_last          (rsp_ch.last)
);

@@ tb/integer_set_table_core_tb.sv @@
`timescale 1ns / 100ps
// testbench for integer_set_table_core: directed and random add, remove, contains and dump
// requests, each response word checked against a shadow copy of the set
// depends on ist_pkg, the ist_req_if / ist_rsp_if interfaces and the core itself
module integer_set_table_core_tb;
   import ist_pkg::*;

   localparam int Capacity       = 16;
   localparam int CycleLimit     = 1000000;
   localparam int RandomWords    = 350;
   localparam int SettleCycles   = 50;   // well beyond the slowest scan
   localparam int LongHoldCycles = 400;
   localparam int PoolSize       = 24;   // more than capacity, so adds and removes both hit
   localparam int ReportLimit    = 10;

   typedef logic signed [ValueWidth-1:0] value_type;

   localparam value_type MinValue = 32'h8000_0000;
   localparam value_type MaxValue = 32'h7fff_ffff;

   // one response word, field for field
   typedef struct packed {
      logic                     was_present;
      logic                     rejected_full;
      logic [CountOutWidth-1:0] member_count;
      value_type                element;
      logic                     element_valid;
      logic                     last;
   } set_reply_type;

   // flavour of a run of random requests
   typedef enum logic [1:0] {
      SEG_MIXED,
      SEG_FILL,
      SEG_DRAIN,
      SEG_PROBE
   } segment_kind_type;

   // shadow of the set plus the queue of words still owed by the block
   class set_shadow_checker;
      value_type     members[Capacity];
      int            member_total;
      set_reply_type owed_replies[$];
      int unsigned   failures;

      function new();
         member_total = 0;
         failures     = 0;
      endfunction

      function int outstanding();
         return owed_replies.size();
      endfunction

      // random current member, or a random value when the set is empty
      function value_type any_member();
         if (member_total == 0) begin
            return $urandom;
         end
         return members[$urandom_range(0, member_total - 1)];
      endfunction

      // work out the words an accepted request causes and update the shadow set
      function void note_request(op_type op, value_type v);
         value_type     sorted[Capacity];
         value_type     swap;
         set_reply_type word;
         int            slot;
         int            least;
         int            i;
         int            j;
         logic          present;
         logic          full;

         word = '0;
         word.last = 1'b1;
         if (op == OP_DUMP) begin
            if (member_total == 0) begin
               // empty dump: a single word flagged as carrying nothing
               owed_replies.push_back(word);
            end else begin
               sorted = members;
               // selection sort on signed values
               for (i = 0; i < member_total - 1; i++) begin
                  least = i;
                  for (j = i + 1; j < member_total; j++) begin
                     if (sorted[j] < sorted[least]) least = j;
                  end
                  swap          = sorted[i];
                  sorted[i]     = sorted[least];
                  sorted[least] = swap;
               end
               for (i = 0; i < member_total; i++) begin
                  word.member_count  = member_total[CountOutWidth-1:0];
                  word.element       = sorted[i];
                  word.element_valid = 1'b1;
                  word.last          = (i == member_total - 1);
                  owed_replies.push_back(word);
               end
            end
         end else begin
            slot = -1;
            for (i = 0; i < member_total; i++) begin
               if (slot < 0 && members[i] == v) slot = i;
            end
            present = (slot >= 0);
            full    = 1'b0;
            if (op == OP_ADD && !present) begin
               if (member_total < Capacity) begin
                  members[member_total] = v;
                  member_total++;
               end else begin
                  full = 1'b1;
               end
            end else if (op == OP_REMOVE && present) begin
               // last entry fills the hole
               members[slot] = members[member_total - 1];
               member_total--;
            end
            word.was_present   = present;
            word.rejected_full = full;
            word.member_count  = member_total[CountOutWidth-1:0];
            owed_replies.push_back(word);
         end
      endfunction

      // compare a response word with the oldest one owed
      function void check_reply(set_reply_type got);
         set_reply_type want;

         if (owed_replies.size() == 0) begin
            failures++;
            if (failures <= ReportLimit) begin
               $display("unexpected response word: present=%0b full=%0b count=%0d",
                        got.was_present, got.rejected_full, got.member_count,
                        " element=%0d valid=%0b last=%0b",
                        got.element, got.element_valid, got.last);
            end
         end else begin
            want = owed_replies.pop_front();
            if (got.was_present !== want.was_present ||
                got.rejected_full !== want.rejected_full ||
                got.member_count !== want.member_count ||
                got.element !== want.element ||
                got.element_valid !== want.element_valid ||
                got.last !== want.last) begin
               failures++;
               if (failures <= ReportLimit) begin
                  $display("mismatch: expected present=%0b full=%0b count=%0d",
                           want.was_present, want.rejected_full, want.member_count,
                           " element=%0d valid=%0b last=%0b",
                           want.element, want.element_valid, want.last);
                  $display("          actual   present=%0b full=%0b count=%0d",
                           got.was_present, got.rejected_full, got.member_count,
                           " element=%0d valid=%0b last=%0b",
                           got.element, got.element_valid, got.last);
               end
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   ist_req_if req_ch ();
   ist_rsp_if rsp_ch ();

   integer_set_table_core #(
      .CAPACITY(Capacity)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   set_shadow_checker set_shadow = new();

   value_type value_pool[PoolSize];
   int        req_idle_pct;
   int        rsp_idle_pct;
   bit        steady;          // final stretch: neither side idles
   bit        long_hold_req;   // asks the response side for one long stall

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   // offer one request word and wait for it to be taken; starts and ends at a falling edge
   task automatic send_request(input op_type op, input value_type v);
      int gap;

      if (!steady && $urandom_range(0, 99) < req_idle_pct) begin
         gap = $urandom_range(1, 13);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.value     <= v;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      set_shadow.note_request(op, v);
      @(negedge clock);
   endtask

   // drop the request and sit until every owed word has arrived
   task automatic wait_for_owed_words();
      req_ch.valid <= 1'b0;
      while (set_shadow.outstanding() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic value_type pool_value();
      return value_pool[$urandom_range(0, PoolSize - 1)];
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0: begin
            return 0;
         end
         1: begin
            return 15;
         end
         default: begin
            return 40;
         end
      endcase
   endfunction

   // response side: ready changes at the falling edge, random stall bursts
   initial begin : reply_pacer
      int stall_left;
      bit hold_taken;

      stall_left   = 0;
      hold_taken   = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_taken) begin
            // long hold-off so the core backs up and refuses requests
            hold_taken = 1'b1;
            stall_left = LongHoldCycles;
         end else if (stall_left == 0 && !steady && $urandom_range(0, 99) < rsp_idle_pct) begin
            stall_left = $urandom_range(1, 13);
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // response words are sampled at the rising edge
   always @(posedge clock) begin : reply_monitor
      set_reply_type seen;

      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen.was_present   = rsp_ch.was_present;
         seen.rejected_full = rsp_ch.rejected_full;
         seen.member_count  = rsp_ch.member_count;
         seen.element       = rsp_ch.element;
         seen.element_valid = rsp_ch.element_valid;
         seen.last          = rsp_ch.last;
         set_shadow.check_reply(seen);
      end
   end

   // watchdog
   initial begin : cycle_guard
      repeat (CycleLimit) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      segment_kind_type kind;
      op_type           op;
      value_type        v;
      int               sent;
      int               seg_len;
      int               seg;
      int               i;
      int               r;
      bit               hold_done;
      bit               pause_done;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = OP_ADD;
      req_ch.value     = '0;
      steady           = 1'b0;
      long_hold_req    = 1'b0;
      req_idle_pct     = 30;
      rsp_idle_pct     = 30;
      hold_done        = 1'b0;
      pause_done       = 1'b0;

      // pool of values that recur, extremes among them
      for (i = 0; i < PoolSize; i++) value_pool[i] = $urandom;
      value_pool[0] = MinValue;
      value_pool[1] = MaxValue;
      value_pool[2] = 0;
      value_pool[3] = -1;
      value_pool[4] = 1;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty set first
      send_request(OP_DUMP, 0);          // empty dump gives one invalid word
      send_request(OP_CONTAINS, 0);
      send_request(OP_REMOVE, 5);        // remove of an absent value
      send_request(OP_ADD, MinValue);
      send_request(OP_ADD, MaxValue);
      send_request(OP_ADD, 0);
      send_request(OP_ADD, -1);
      send_request(OP_ADD, 1);
      send_request(OP_ADD, 0);           // already present
      send_request(OP_CONTAINS, MaxValue);
      send_request(OP_CONTAINS, 2);
      send_request(OP_DUMP, -1);         // value is ignored on a dump
      send_request(OP_REMOVE, MinValue); // first slot, last entry moves in
      send_request(OP_REMOVE, -1);       // now the last entry
      send_request(OP_REMOVE, -1);
      send_request(OP_DUMP, MaxValue);

      // random segments; the first one is always a fill segment of Capacity + 4 requests
      sent = 0;
      seg  = 0;
      while (sent < RandomWords) begin
         kind = (seg == 0) ? SEG_FILL : segment_kind_type'($urandom_range(0, 3));
         seg_len = (kind == SEG_FILL) ? Capacity + 4 : $urandom_range(8, 30);
         req_idle_pct = pick_idle_pct();
         rsp_idle_pct = pick_idle_pct();

         if (!hold_done && sent >= 100) begin
            // sender keeps offering while the response side holds off
            long_hold_req = 1'b1;
            req_idle_pct  = 0;
            hold_done     = 1'b1;
         end
         if (!pause_done && sent >= 200) begin
            wait_for_owed_words();
            pause_done = 1'b1;
         end
         if (sent >= RandomWords - 40) steady = 1'b1;

         for (i = 0; i < seg_len; i++) begin
            r = $urandom_range(0, 99);
            case (kind)
               SEG_FILL: begin
                  if (r < 80) begin
                     op = OP_ADD;
                     v  = $urandom;
                  end else if (r < 90) begin
                     op = OP_ADD;
                     v  = pool_value();
                  end else begin
                     op = OP_DUMP;
                     v  = $urandom;
                  end
               end
               SEG_DRAIN: begin
                  if (r < 70) begin
                     op = OP_REMOVE;
                     v  = set_shadow.any_member();
                  end else if (r < 85) begin
                     op = OP_REMOVE;
                     v  = pool_value();
                  end else if (r < 95) begin
                     op = OP_CONTAINS;
                     v  = set_shadow.any_member();
                  end else begin
                     op = OP_DUMP;
                     v  = $urandom;
                  end
               end
               SEG_PROBE: begin
                  if (r < 45) begin
                     op = OP_CONTAINS;
                     v  = set_shadow.any_member();
                  end else if (r < 80) begin
                     op = OP_CONTAINS;
                     v  = ($urandom_range(0, 1) == 0) ? pool_value() : value_type'($urandom);
                  end else begin
                     op = OP_DUMP;
                     v  = $urandom;
                  end
               end
               default: begin
                  if (r < 40) begin
                     op = OP_ADD;
                     v  = pool_value();
                  end else if (r < 65) begin
                     op = OP_REMOVE;
                     v  = pool_value();
                  end else if (r < 85) begin
                     op = OP_CONTAINS;
                     v  = pool_value();
                  end else begin
                     op = OP_DUMP;
                     v  = $urandom;
                  end
               end
            endcase
            send_request(op, v);
            sent++;
         end
         seg++;
      end

      // drain, then allow a few scans' worth of cycles for any stray word
      wait_for_owed_words();
      repeat (SettleCycles) @(posedge clock);

      if (set_shadow.failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
